// ===== src/rsi_pkg.sv =====
// Shared types and constants for the ray/sphere intersection pipeline.
package rsi_pkg;

  localparam int SQ_STAGES = 37;
  localparam int DV_STAGES = 31;

  localparam logic signed [37:0] EPS_T = 38'sd6;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][31:0] dir;
  } ray_t;

  typedef struct packed {
    logic        valid;
    logic        miss;
    logic [36:0] b;
    ray_t        ray;
  } sq_side_t;

  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [2:0][31:0] hitp;
    logic [2:0]       neg;
    logic [2:0]       big;
  } dv_side_t;

endpackage

// ===== src/rsi_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with side data.
module rsi_sqrt
  import rsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [73:0] rad,
  input  sq_side_t    side_in,
  output logic [36:0] root,
  output sq_side_t    side_out
);

  logic [39:0] rem_q  [SQ_STAGES];
  logic [36:0] root_q [SQ_STAGES];
  logic [73:0] rad_q  [SQ_STAGES];
  sq_side_t    side_q [SQ_STAGES];

  logic [39:0] cur_rem  [SQ_STAGES];
  logic [36:0] cur_root [SQ_STAGES];
  logic [73:0] cur_rad  [SQ_STAGES];
  sq_side_t    cur_side [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    logic [39:0] sh;
    logic [39:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign cur_rem[k]  = '0;
      assign cur_root[k] = '0;
      assign cur_rad[k]  = rad;
      assign cur_side[k] = side_in;
    end else begin : g_next
      assign cur_rem[k]  = rem_q[k-1];
      assign cur_root[k] = root_q[k-1];
      assign cur_rad[k]  = rad_q[k-1];
      assign cur_side[k] = side_q[k-1];
    end

    assign sh    = {cur_rem[k][37:0], cur_rad[k][73:72]};
    assign trial = {1'b0, cur_root[k], 2'b01};
    assign ge    = (sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? (sh - trial) : sh;
        root_q[k] <= {cur_root[k][35:0], ge};
        rad_q[k]  <= {cur_rad[k][71:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side_q[k].valid <= 1'b0;
      end else if (en) begin
        side_q[k] <= cur_side[k];
      end
    end
  end

  assign root     = root_q[SQ_STAGES-1];
  assign side_out = side_q[SQ_STAGES-1];

endmodule

// ===== src/rsi_div.sv =====
// Three-lane pipelined restoring divider by the radius, one quotient bit per stage.
module rsi_div
  import rsi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [30:0]      rdiv,
  input  logic [2:0][30:0] rem_in,
  input  logic [2:0]       lsb,
  input  dv_side_t         side_in,
  output logic [2:0][30:0] quo,
  output dv_side_t         side_out
);

  logic [2:0][30:0] rem_q  [DV_STAGES];
  logic [2:0][30:0] quo_q  [DV_STAGES];
  dv_side_t         side_q [DV_STAGES];

  logic [2:0][30:0] cur_rem  [DV_STAGES];
  logic [2:0][30:0] cur_quo  [DV_STAGES];
  logic [2:0]       cur_bit  [DV_STAGES];
  dv_side_t         cur_side [DV_STAGES];

  for (genvar j = 0; j < DV_STAGES; j++) begin : g_stage
    logic [2:0][30:0] rem_next;
    logic [2:0][30:0] quo_next;

    if (j == 0) begin : g_first
      assign cur_rem[j]  = rem_in;
      assign cur_quo[j]  = '0;
      assign cur_bit[j]  = lsb;
      assign cur_side[j] = side_in;
    end else begin : g_next
      assign cur_rem[j]  = rem_q[j-1];
      assign cur_quo[j]  = quo_q[j-1];
      assign cur_bit[j]  = '0;
      assign cur_side[j] = side_q[j-1];
    end

    always_comb begin
      logic [31:0] sh;
      logic [31:0] dif;
      for (int l = 0; l < 3; l++) begin
        sh  = {cur_rem[j][l], cur_bit[j][l]};
        dif = sh - {1'b0, rdiv};
        if (sh >= {1'b0, rdiv}) begin
          rem_next[l] = dif[30:0];
          quo_next[l] = {cur_quo[j][l][29:0], 1'b1};
        end else begin
          rem_next[l] = sh[30:0];
          quo_next[l] = {cur_quo[j][l][29:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= rem_next;
        quo_q[j] <= quo_next;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side_q[j].valid <= 1'b0;
      end else if (en) begin
        side_q[j] <= cur_side[j];
      end
    end
  end

  assign quo      = quo_q[DV_STAGES-1];
  assign side_out = side_q[DV_STAGES-1];

endmodule

// ===== src/ray_sphere_intersect.sv =====
// Top level: ray against sphere intersection pipeline.
//
// Rays come in on the s_axis channel, one beat per ray: origin x/y/z in
// Q16.16, then direction x/y/z in Q2.30. Each ray gives exactly one beat on
// m_axis: tuser is the hit flag, tdata the hit point (Q16.16) and the unit
// normal (Q2.30), all zero on a miss.
// Sphere center and radius are set through cfg_we/cfg_addr/cfg_wdata while
// no ray is in flight. Reset puts the center at the origin, radius at 1.0.
// A ray passes 5 setup stages, 37 square root stages (one root bit each),
// 4 stages for root pick, hit point and normal setup, 31 divider stages
// (one quotient bit each), and the output register. Throughput is one ray
// per cycle while the output beat is not held by the receiver.
// The whole pipeline advances together; while the output beat is held by
// the receiver, s_axis_tready is low and nothing moves, so no beat is lost.
// Reset clears all valid bits and the output valid.
module ray_sphere_intersect
  import rsi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_x, hit_y, hit_z, normal_x, normal_y, normal_z
  output logic [191:0] m_axis_tdata,
  // hit
  output logic         m_axis_tuser,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  logic signed [31:0] center [3];
  logic [30:0]        radius;
  logic [30:0]        rdiv;
  logic               en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) center[i] <= '0;
      radius <= 31'd65536;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_CENTER_X: center[0] <= cfg_wdata;
        REG_CENTER_Y: center[1] <= cfg_wdata;
        REG_CENTER_Z: center[2] <= cfg_wdata;
        REG_RADIUS:   radius    <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  assign rdiv          = (radius == '0) ? 31'd1 : radius;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  function automatic logic [31:0] sat32(input logic signed [40:0] v);
    logic [31:0] r;
    if (!v[40] && (|v[39:31])) r = 32'h7FFF_FFFF;
    else if (v[40] && !(&v[39:31])) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // setup stages
  logic [4:1]         vld;
  ray_t               ray1, ray2, ray3, ray4;
  logic signed [32:0] oc1 [3];
  logic signed [64:0] pd2 [3];
  logic signed [65:0] ocsq2 [3];
  logic signed [66:0] dsum;
  logic signed [36:0] b3, b4;
  logic [67:0]        q3, q4;
  logic signed [73:0] bsq4;
  logic [61:0]        rsq4;
  logic [74:0]        dw;
  logic [73:0]        d5;
  sq_side_t           side5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:1], s_axis_tvalid};
    end
  end

  assign dsum = 67'(pd2[0]) + 67'(pd2[1]) + 67'(pd2[2]);
  assign dw   = 75'(bsq4) + 75'(rsq4) - 75'(q4);

  always_ff @(posedge clk) begin
    if (rst) begin
      side5.valid <= 1'b0;
    end else if (en) begin
      side5.valid <= vld[4];
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ray1.org[i] <= s_axis_tdata[32*i +: 32];
        ray1.dir[i] <= s_axis_tdata[96+32*i +: 32];
        oc1[i]      <= 33'(center[i]) - 33'($signed(s_axis_tdata[32*i +: 32]));
        pd2[i]      <= $signed(ray1.dir[i]) * oc1[i];
        ocsq2[i]    <= oc1[i] * oc1[i];
      end
      ray2       <= ray1;
      ray3       <= ray2;
      ray4       <= ray3;
      b3         <= dsum[66:30];
      q3         <= 68'(ocsq2[0]) + 68'(ocsq2[1]) + 68'(ocsq2[2]);
      bsq4       <= b3 * b3;
      rsq4       <= radius * radius;
      q4         <= q3;
      b4         <= b3;
      d5         <= dw[73:0];
      side5.miss <= dw[74];
      side5.b    <= b4;
      side5.ray  <= ray4;
    end
  end

  logic [36:0] root_s;
  sq_side_t    side_s;

  rsi_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .rad      (d5),
    .side_in  (side5),
    .root     (root_s),
    .side_out (side_s)
  );

  // root pick, hit point, normal setup
  logic signed [37:0] lo_t, hi_t, t_sel, t6;
  logic               hit_sel;
  logic               v6, hit6, v7, hit7, v8, hit8;
  ray_t               ray6;
  logic [2:0][31:0]   org7;
  logic signed [69:0] step7 [3];
  logic [2:0][31:0]   hp8;
  logic signed [40:0] ps [3];

  always_comb begin
    lo_t    = 38'($signed(side_s.b)) - $signed({1'b0, root_s});
    hi_t    = 38'($signed(side_s.b)) + $signed({1'b0, root_s});
    t_sel   = (lo_t > EPS_T) ? lo_t : hi_t;
    hit_sel = !side_s.miss && ((lo_t > EPS_T) || (hi_t > EPS_T));
    for (int i = 0; i < 3; i++) begin
      ps[i] = 41'($signed(org7[i])) + 41'($signed(step7[i][69:30]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (en) begin
      v6 <= side_s.valid;
      v7 <= v6;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t6   <= t_sel;
      hit6 <= hit_sel;
      ray6 <= side_s.ray;
      hit7 <= hit6;
      org7 <= ray6.org;
      hit8 <= hit7;
      for (int i = 0; i < 3; i++) begin
        step7[i] <= t6 * $signed(ray6.dir[i]);
        hp8[i]   <= sat32(ps[i]);
      end
    end
  end

  logic signed [32:0] diff [3];
  logic [32:0]        absd [3];
  dv_side_t           dside_next, dside9;
  logic [2:0][30:0]   rem9;
  logic [2:0]         lsb9;

  always_comb begin
    dside_next.valid = v8;
    dside_next.hit   = hit8;
    dside_next.hitp  = hp8;
    for (int i = 0; i < 3; i++) begin
      diff[i]              = 33'($signed(hp8[i])) - 33'(center[i]);
      absd[i]              = diff[i][32] ? 33'(-diff[i]) : 33'(diff[i]);
      dside_next.neg[i]    = diff[i][32];
      dside_next.big[i]    = (absd[i] >= {1'b0, rdiv, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dside9.valid <= 1'b0;
    end else if (en) begin
      dside9 <= dside_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rem9[i] <= absd[i][31:1];
        lsb9[i] <= absd[i][0];
      end
    end
  end

  logic [2:0][30:0] quo_d;
  dv_side_t         side_d;

  rsi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .rdiv     (rdiv),
    .rem_in   (rem9),
    .lsb      (lsb9),
    .side_in  (dside9),
    .quo      (quo_d),
    .side_out (side_d)
  );

  // output register
  logic [2:0][31:0] nrm;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (side_d.big[i]) begin
        nrm[i] = side_d.neg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        nrm[i] = side_d.neg[i] ? (32'd0 - {1'b0, quo_d[i]}) : {1'b0, quo_d[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= side_d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tuser <= side_d.hit;
      m_axis_tdata <= side_d.hit ? {nrm[2], nrm[1], nrm[0], side_d.hitp[2],
                                    side_d.hitp[1], side_d.hitp[0]} : '0;
    end
  end

endmodule
